@@ sv/smu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and codes of the sorted merge union block.
// ----------------------------------------------------------------------------
package smu_pkg;

   localparam int KEY_W = 27;
   localparam int TAG_W = 16;
   localparam int CMD_W = 2;
   localparam int SRC_W = 2;
   localparam int POS_W = 6;

   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

   localparam logic [SRC_W-1:0] SRC_A    = 2'd0;
   localparam logic [SRC_W-1:0] SRC_B    = 2'd1;
   localparam logic [SRC_W-1:0] SRC_BOTH = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } record_type;

endpackage

@@ sv/sorted_merge_union.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_merge_union
// Loads two key-ordered record lists and streams their union in key order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | command, key, tag
//  rsp_    | out       | rsp_valid/rsp_stall  | out_key, out_tag, source, position,
//          |           |                      | empty_res, overflow, last
//
// A load transaction is taken whenever req_stall is low. A merge starts from
// idle, and each result then takes a registered store read and a pick of the
// record by the shared key comparator. Up to 2 * LIST_DEPTH results.
// Reset clears the fill counts, the overflow flag and the sequencer; store
// contents are not cleared. While a merge runs req_stall is high, and a held
// result on rsp_ pauses the sequencer until it is taken.
// ----------------------------------------------------------------------------
module sorted_merge_union
   import smu_pkg::*;
#(
   parameter int LIST_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CMD_W-1:0] req_command,
   input  logic [KEY_W-1:0] req_key,
   input  logic [TAG_W-1:0] req_tag,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [KEY_W-1:0] rsp_out_key,
   output logic [TAG_W-1:0] rsp_out_tag,
   output logic [SRC_W-1:0] rsp_source,
   output logic [POS_W-1:0] rsp_position,
   output logic             rsp_empty_res,
   output logic             rsp_overflow,
   output logic             rsp_last
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

   logic [CNT_W-1:0] count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic             overflow_ff, overflow_in;

   logic             req_accept, is_load_a, is_load_b, wr_a, wr_b, start;
   logic             busy, done;
   logic [IDX_W-1:0] addr_a, addr_b;
   record_type       wr_rec, rd_a, rd_b;

   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;
   assign is_load_a  = req_accept && (req_command == CMD_LOAD_A);
   assign is_load_b  = req_accept && (req_command == CMD_LOAD_B);
   assign start      = req_accept && (req_command == CMD_MERGE);
   assign wr_a       = is_load_a && (count_a_ff < DEPTH_C);
   assign wr_b       = is_load_b && (count_b_ff < DEPTH_C);
   assign wr_rec     = '{key: req_key, tag: req_tag};

   always_comb begin
      count_a_in  = count_a_ff;
      count_b_in  = count_b_ff;
      overflow_in = overflow_ff;
      if (done) begin
         count_a_in  = '0;
         count_b_in  = '0;
         overflow_in = 1'b0;
      end else begin
         if (wr_a) begin
            count_a_in = count_a_ff + CNT_W'(1);
         end
         if (wr_b) begin
            count_b_in = count_b_ff + CNT_W'(1);
         end
         // A load into a full list is dropped but remembered.
         if ((is_load_a && !wr_a) || (is_load_b && !wr_b)) begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff  <= '0;
         count_b_ff  <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_a_ff  <= count_a_in;
         count_b_ff  <= count_b_in;
         overflow_ff <= overflow_in;
      end
   end

   smu_list_store #(.DEPTH(LIST_DEPTH), .IDX_W(IDX_W)) u_store_a (
      .clock      (clock),
      .wr_en      (wr_a),
      .wr_addr    (count_a_ff[IDX_W-1:0]),
      .wr_data    (wr_rec),
      .rd_addr    (addr_a),
      .rd_data_ff (rd_a)
   );

   smu_list_store #(.DEPTH(LIST_DEPTH), .IDX_W(IDX_W)) u_store_b (
      .clock      (clock),
      .wr_en      (wr_b),
      .wr_addr    (count_b_ff[IDX_W-1:0]),
      .wr_data    (wr_rec),
      .rd_addr    (addr_b),
      .rd_data_ff (rd_b)
   );

   smu_merge_ctrl #(.LIST_DEPTH(LIST_DEPTH), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .count_a         (count_a_ff),
      .count_b         (count_b_ff),
      .overflow        (overflow_ff),
      .rd_a            (rd_a),
      .rd_b            (rd_b),
      .addr_a          (addr_a),
      .addr_b          (addr_b),
      .busy            (busy),
      .done            (done),
      .rsp_stall       (rsp_stall),
      .rsp_valid_ff    (rsp_valid),
      .rsp_key_ff      (rsp_out_key),
      .rsp_tag_ff      (rsp_out_tag),
      .rsp_source_ff   (rsp_source),
      .rsp_position_ff (rsp_position),
      .rsp_empty_ff    (rsp_empty_res),
      .rsp_overflow_ff (rsp_overflow),
      .rsp_last_ff     (rsp_last)
   );

endmodule

@@ sv/smu_list_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_list_store
// Record memory for one list: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smu_list_store
   import smu_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  record_type       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output record_type       rd_data_ff
);

   record_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ sv/smu_merge_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_merge_ctrl
// Merge sequencer: walks both lists through one key comparator and fills the
// result register, one result per pass.
// ----------------------------------------------------------------------------
module smu_merge_ctrl
   import smu_pkg::*;
#(
   parameter int LIST_DEPTH = 32,
   parameter int CNT_W      = 6,
   parameter int IDX_W      = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] count_a,
   input  logic [CNT_W-1:0] count_b,
   input  logic             overflow,
   input  record_type       rd_a,
   input  record_type       rd_b,
   output logic [IDX_W-1:0] addr_a,
   output logic [IDX_W-1:0] addr_b,
   output logic             busy,
   output logic             done,
   input  logic             rsp_stall,
   output logic             rsp_valid_ff,
   output logic [KEY_W-1:0] rsp_key_ff,
   output logic [TAG_W-1:0] rsp_tag_ff,
   output logic [SRC_W-1:0] rsp_source_ff,
   output logic [POS_W-1:0] rsp_position_ff,
   output logic             rsp_empty_ff,
   output logic             rsp_overflow_ff,
   output logic             rsp_last_ff
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             rsp_valid_in;
   logic [KEY_W-1:0] rsp_key_in;
   logic [TAG_W-1:0] rsp_tag_in;
   logic [SRC_W-1:0] rsp_source_in;
   logic [POS_W-1:0] rsp_position_in;
   logic             rsp_empty_in, rsp_overflow_in, rsp_last_in;

   logic             a_has, b_has, key_lt, key_eq;
   logic             adv_a, adv_b, pick_a, none_left, last_sel, slot_free;
   logic [SRC_W-1:0] sel_src;
   logic [CNT_W-1:0] ptr_a_nx, ptr_b_nx;

   // An exhausted full list would point past the store; park it at entry zero.
   assign addr_a = (ptr_a_ff < DEPTH_C) ? ptr_a_ff[IDX_W-1:0] : '0;
   assign addr_b = (ptr_b_ff < DEPTH_C) ? ptr_b_ff[IDX_W-1:0] : '0;
   assign busy   = (state_ff != ST_IDLE);

   // The shared comparator.
   assign key_lt = (rd_a.key < rd_b.key);
   assign key_eq = (rd_a.key == rd_b.key);

   assign a_has     = (ptr_a_ff < count_a);
   assign b_has     = (ptr_b_ff < count_b);
   assign none_left = !a_has && !b_has;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      adv_a   = 1'b0;
      adv_b   = 1'b0;
      pick_a  = 1'b1;
      sel_src = SRC_A;
      priority if (none_left) begin
         sel_src = SRC_A;
      end else if (a_has && (!b_has || key_lt)) begin
         adv_a = 1'b1;
      end else if (b_has && (!a_has || !key_eq)) begin
         adv_b   = 1'b1;
         pick_a  = 1'b0;
         sel_src = SRC_B;
      end else begin
         adv_a   = 1'b1;
         adv_b   = 1'b1;
         sel_src = SRC_BOTH;
      end
   end

   assign ptr_a_nx = ptr_a_ff + CNT_W'(adv_a);
   assign ptr_b_nx = ptr_b_ff + CNT_W'(adv_b);
   assign last_sel = !(ptr_a_nx < count_a) && !(ptr_b_nx < count_b);

   always_comb begin
      state_in        = state_ff;
      ptr_a_in        = ptr_a_ff;
      ptr_b_in        = ptr_b_ff;
      pos_in          = pos_ff;
      done            = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_key_in      = rsp_key_ff;
      rsp_tag_in      = rsp_tag_ff;
      rsp_source_in   = rsp_source_ff;
      rsp_position_in = rsp_position_ff;
      rsp_empty_in    = rsp_empty_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_last_in     = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ptr_a_in = '0;
               ptr_b_in = '0;
               pos_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_key_in      = none_left ? '0 : (pick_a ? rd_a.key : rd_b.key);
               rsp_tag_in      = none_left ? '0 : (pick_a ? rd_a.tag : rd_b.tag);
               rsp_source_in   = sel_src;
               rsp_position_in = pos_ff;
               rsp_empty_in    = none_left;
               rsp_overflow_in = overflow;
               rsp_last_in     = last_sel;
               ptr_a_in        = ptr_a_nx;
               ptr_b_in        = ptr_b_nx;
               pos_in          = pos_ff + POS_W'(1);
               if (last_sel) begin
                  done     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff      <= rsp_key_in;
      rsp_tag_ff      <= rsp_tag_in;
      rsp_source_ff   <= rsp_source_in;
      rsp_position_ff <= rsp_position_in;
      rsp_empty_ff    <= rsp_empty_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_last_ff     <= rsp_last_in;
   end

endmodule

@@ sv/smu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smu_checker
// Port-level checks of the sorted merge union block, bound to the top level.
// ----------------------------------------------------------------------------
module smu_checker
   import smu_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [CMD_W-1:0] req_command,
   input logic [KEY_W-1:0] req_key,
   input logic [TAG_W-1:0] req_tag,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [KEY_W-1:0] rsp_out_key,
   input logic [TAG_W-1:0] rsp_out_tag,
   input logic [SRC_W-1:0] rsp_source,
   input logic [POS_W-1:0] rsp_position,
   input logic             rsp_empty_res,
   input logic             rsp_overflow,
   input logic             rsp_last
);

   // A held result transaction stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_out_tag) && $stable(rsp_position) && $stable(rsp_last))
      else $error("result changed while stalled");

   // The empty-merge result is alone in its run.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_position == '0))
      else $error("empty result not the sole result of its merge");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> (rsp_out_key == '0) && (rsp_out_tag == '0)
         && (rsp_source == SRC_A))
      else $error("empty result carries record fields");

   // An accepted merge keeps the request side closed in the next cycle.
   a_merge_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == CMD_MERGE) |=> req_stall)
      else $error("request side open right after a merge");

endmodule

bind sorted_merge_union smu_checker u_smu_checker (.*);
